[rtl/nvrs_pkg.sv]
// Shared types, constants and helper functions of the nearest value request scheduler.
package nvrs_pkg;

  localparam int MaxEntries    = 16;
  localparam int MaxRequesters = 16;
  localparam int ValueBits     = 10;

  localparam int IdxW    = $clog2(MaxEntries);
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int ReqW    = $clog2(MaxRequesters);
  localparam int ReqCntW = $clog2(MaxRequesters + 1);
  localparam int CfgW    = 5;
  localparam int CfgAddrW = 1;
  localparam int DistW   = ValueBits + 1;
  localparam int LastW   = ValueBits + 1;
  localparam int ScanW   = $clog2(MaxEntries + 1);

  // Register indexes of the configuration port.
  localparam logic [CfgAddrW-1:0] CFG_CAPACITY  = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_REQ_COUNT = 1'b1;

  // Request modes.
  localparam logic MODE_POST = 1'b0;
  localparam logic MODE_DONE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PENDING  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_INACTIVE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SERVE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ReqW-1:0]      req;
    logic [ValueBits-1:0] val;
  } entry_t;

  // Best candidate travelling down the chain of cells.
  typedef struct packed {
    logic             found;
    logic [DistW-1:0] span;
    logic [IdxW-1:0]  idx;
    entry_t           entry;
  } best_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic [IdxW-1:0]         pick;
    logic [CntW-1:0]         count;
    entry_t                  new_entry;
    logic signed [LastW-1:0] last;
  } cell_ctrl_t;

  typedef struct packed {
    status_e              status;
    logic                 served;
    logic [ReqW-1:0]      served_req;
    logic [ValueBits-1:0] served_val;
  } result_t;

  function automatic logic [CntW-1:0] sat_capacity(logic [CfgW-1:0] raw);
    logic [CntW-1:0] res;
    if (raw == '0) begin
      res = CntW'(1);
    end else if (int'(raw) > MaxEntries) begin
      res = CntW'(MaxEntries);
    end else begin
      res = CntW'(raw);
    end
    return res;
  endfunction

  function automatic logic [ReqCntW-1:0] sat_requesters(logic [CfgW-1:0] raw);
    logic [ReqCntW-1:0] res;
    if (raw == '0) begin
      res = ReqCntW'(1);
    end else if (int'(raw) > MaxRequesters) begin
      res = ReqCntW'(MaxRequesters);
    end else begin
      res = ReqCntW'(raw);
    end
    return res;
  endfunction

endpackage

[rtl/nvrs_if.sv]
// Handshake channel interfaces of the nearest value request scheduler.
interface nvrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [nvrs_pkg::ReqW-1:0]     requester;
  logic [nvrs_pkg::ValueBits-1:0] order_value;

  modport source (output valid, mode, requester, order_value, input ready);
  modport sink   (input valid, mode, requester, order_value, output ready);
endinterface

interface nvrs_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic                           served;
  logic [nvrs_pkg::ReqW-1:0]      served_requester;
  logic [nvrs_pkg::ValueBits-1:0] served_value;

  modport source (output valid, status, served, served_requester, served_value, input ready);
  modport sink   (input valid, status, served, served_requester, served_value, output ready);
endinterface

interface nvrs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nvrs_pkg::CfgAddrW-1:0] addr;
  logic [nvrs_pkg::CfgW-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/nvrs_cell.sv]
// One board slot: holds an entry, shifts and loads it, and folds it into the nearest search.
module nvrs_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [nvrs_pkg::IdxW-1:0] idx_i,
  input  nvrs_pkg::cell_ctrl_t      ctrl_i,
  input  nvrs_pkg::entry_t          next_i,
  input  nvrs_pkg::best_t           best_i,
  output nvrs_pkg::entry_t          entry_o,
  output nvrs_pkg::best_t           best_o
);

  nvrs_pkg::entry_t entry_q, entry_d;
  nvrs_pkg::best_t  best_q, best_d;

  logic                             occupied;
  logic signed [nvrs_pkg::LastW:0]  diff;
  logic [nvrs_pkg::DistW-1:0]       span;

  always_comb begin
    occupied = int'(idx_i) < int'(ctrl_i.count);
    diff = $signed({2'b00, entry_q.val}) -
           $signed({ctrl_i.last[nvrs_pkg::LastW-1], ctrl_i.last});
    span = diff[nvrs_pkg::LastW] ? nvrs_pkg::DistW'(-diff) : nvrs_pkg::DistW'(diff);

    entry_d = entry_q;
    if (ctrl_i.shift && (idx_i >= ctrl_i.pick)) begin
      entry_d = next_i;
    end else if (ctrl_i.insert && (int'(idx_i) == int'(ctrl_i.count))) begin
      entry_d = ctrl_i.new_entry;
    end

    // Strict compare keeps the older entry on equal distance.
    best_d = best_i;
    if (occupied && (!best_i.found || (span < best_i.span))) begin
      best_d.found = 1'b1;
      best_d.span  = span;
      best_d.idx   = idx_i;
      best_d.entry = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign entry_o = entry_q;
  assign best_o  = best_q;

endmodule

[rtl/nearest_value_request_scheduler.sv]
// Top level of the nearest value request scheduler: sequencer, bookkeeping and cell chain.
//
// Requests enter on in_ch (mode, requester, order_value) and one result per request
// leaves on out_ch (status, served, served_requester, served_value). Both channels
// transfer when valid and ready are high at a rising clock edge. cfg_ch writes the
// board capacity (addr 0) and the requester count (addr 1, which also reloads the
// active counter); it is always ready and is meant to be used while the block is idle.
// The board lives in a chain of cells. The nearest-value search is a wave that moves
// one cell per cycle. A request that serves an entry passes through the states check,
// scan (until the wave has passed every cell), serve and finish; a request that serves
// nothing goes from check straight to finish. The finish state loads the result. One
// request is worked on at a time; in_ch is ready again right after the result is loaded
// into the output register, so a new request is accepted only once the last is done.
// If the receiver stalls, the result waits in the output register while the next
// request is already accepted and processed; that request then holds in its final
// step until the output register is free.
// Reset empties the board, clears the pending and finished masks, sets both
// registers to 16, the active counter to 16 and the last served value to minus one.
module nearest_value_request_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  nvrs_in_if.sink       in_ch,
  nvrs_out_if.source    out_ch,
  nvrs_cfg_if.sink      cfg_ch
);

  localparam logic [nvrs_pkg::ScanW-1:0] ScanLast = nvrs_pkg::ScanW'(nvrs_pkg::MaxEntries - 1);

  nvrs_pkg::state_e                    state_q, state_d;
  logic [nvrs_pkg::CfgW-1:0]           cap_q, cap_d;
  logic [nvrs_pkg::CfgW-1:0]           reqc_q, reqc_d;
  logic [nvrs_pkg::ReqCntW-1:0]        active_q, active_d;
  logic [nvrs_pkg::CntW-1:0]           count_q, count_d;
  logic [nvrs_pkg::MaxRequesters-1:0]  pending_q, pending_d;
  logic [nvrs_pkg::MaxRequesters-1:0]  finished_q, finished_d;
  logic signed [nvrs_pkg::LastW-1:0]   last_q, last_d;
  logic [nvrs_pkg::ScanW-1:0]          scan_q, scan_d;
  nvrs_pkg::result_t                   res_q, res_d;
  nvrs_pkg::result_t                   out_res_q, out_res_d;
  logic                                out_valid_q, out_valid_d;

  logic [nvrs_pkg::CntW-1:0]           eff_cap;
  logic [nvrs_pkg::ReqCntW-1:0]        eff_req;
  logic                                known;
  logic                                serve_cond;
  nvrs_pkg::cell_ctrl_t                ctrl;
  nvrs_pkg::entry_t                    entries [nvrs_pkg::MaxEntries];
  nvrs_pkg::best_t                     bests   [nvrs_pkg::MaxEntries];
  nvrs_pkg::best_t                     best_last;

  assign best_last = bests[nvrs_pkg::MaxEntries-1];

  always_comb begin
    eff_cap = nvrs_pkg::sat_capacity(cap_q);
    eff_req = nvrs_pkg::sat_requesters(reqc_q);
    known   = int'(in_ch.requester) < int'(eff_req);
    // count >= min(active, capacity) is the same as reaching either one.
    serve_cond = (count_q != '0) &&
                 ((int'(count_q) >= int'(active_q)) || (int'(count_q) >= int'(eff_cap)));

    state_d     = state_q;
    cap_d       = cap_q;
    reqc_d      = reqc_q;
    active_d    = active_q;
    count_d     = count_q;
    pending_d   = pending_q;
    finished_d  = finished_q;
    last_d      = last_q;
    scan_d      = scan_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q;

    ctrl           = '0;
    ctrl.count     = count_q;
    ctrl.last      = last_q;
    ctrl.pick      = best_last.idx;
    ctrl.new_entry.req = in_ch.requester;
    ctrl.new_entry.val = in_ch.order_value;

    in_ch.ready  = (state_q == nvrs_pkg::S_IDLE);
    cfg_ch.ready = 1'b1;

    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      nvrs_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          res_d = '0;
          if (!known || finished_q[in_ch.requester]) begin
            res_d.status = nvrs_pkg::STATUS_INACTIVE;
          end else if (pending_q[in_ch.requester]) begin
            res_d.status = nvrs_pkg::STATUS_PENDING;
          end else if (in_ch.mode == nvrs_pkg::MODE_POST) begin
            if (count_q >= eff_cap) begin
              res_d.status = nvrs_pkg::STATUS_FULL;
            end else begin
              res_d.status = nvrs_pkg::STATUS_OK;
              ctrl.insert  = 1'b1;
              count_d      = count_q + nvrs_pkg::CntW'(1);
              pending_d[in_ch.requester] = 1'b1;
            end
          end else begin
            res_d.status = nvrs_pkg::STATUS_OK;
            finished_d[in_ch.requester] = 1'b1;
            if (active_q != '0) begin
              active_d = active_q - nvrs_pkg::ReqCntW'(1);
            end
          end
          state_d = nvrs_pkg::S_CHECK;
        end
      end
      nvrs_pkg::S_CHECK: begin
        if (serve_cond) begin
          scan_d  = '0;
          state_d = nvrs_pkg::S_SCAN;
        end else begin
          state_d = nvrs_pkg::S_FINISH;
        end
      end
      nvrs_pkg::S_SCAN: begin
        // Give the search wave time to pass through every cell.
        scan_d = scan_q + nvrs_pkg::ScanW'(1);
        if (scan_q == ScanLast) begin
          state_d = nvrs_pkg::S_SERVE;
        end
      end
      nvrs_pkg::S_SERVE: begin
        ctrl.shift       = 1'b1;
        count_d          = count_q - nvrs_pkg::CntW'(1);
        pending_d[best_last.entry.req] = 1'b0;
        last_d           = $signed({1'b0, best_last.entry.val});
        res_d.served     = 1'b1;
        res_d.served_req = best_last.entry.req;
        res_d.served_val = best_last.entry.val;
        state_d          = nvrs_pkg::S_FINISH;
      end
      nvrs_pkg::S_FINISH: begin
        if (!out_valid_q || out_ch.ready) begin
          out_res_d   = res_q;
          out_valid_d = 1'b1;
          state_d     = nvrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nvrs_pkg::S_IDLE;
      end
    endcase

    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        nvrs_pkg::CFG_CAPACITY: begin
          cap_d = cfg_ch.data;
        end
        nvrs_pkg::CFG_REQ_COUNT: begin
          reqc_d   = cfg_ch.data;
          active_d = nvrs_pkg::sat_requesters(cfg_ch.data);
        end
        default: begin
          cap_d = cap_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nvrs_pkg::S_IDLE;
      cap_q       <= nvrs_pkg::CfgW'(nvrs_pkg::MaxEntries);
      reqc_q      <= nvrs_pkg::CfgW'(nvrs_pkg::MaxRequesters);
      active_q    <= nvrs_pkg::ReqCntW'(nvrs_pkg::MaxRequesters);
      count_q     <= '0;
      pending_q   <= '0;
      finished_q  <= '0;
      last_q      <= '1;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      reqc_q      <= reqc_d;
      active_q    <= active_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      finished_q  <= finished_d;
      last_q      <= last_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  for (genvar g = 0; g < nvrs_pkg::MaxEntries; g++) begin : g_cell
    nvrs_pkg::best_t  best_in;
    nvrs_pkg::entry_t next_in;

    if (g == 0) begin : g_head
      assign best_in = '0;
    end else begin : g_link
      assign best_in = bests[g-1];
    end

    if (g == nvrs_pkg::MaxEntries - 1) begin : g_tail
      assign next_in = '0;
    end else begin : g_next
      assign next_in = entries[g+1];
    end

    nvrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (nvrs_pkg::IdxW'(g)),
      .ctrl_i  (ctrl),
      .next_i  (next_in),
      .best_i  (best_in),
      .entry_o (entries[g]),
      .best_o  (bests[g])
    );
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.status           = out_res_q.status;
  assign out_ch.served           = out_res_q.served;
  assign out_ch.served_requester = out_res_q.served_req;
  assign out_ch.served_value     = out_res_q.served_val;

endmodule
